### rtl/irw_pkg.sv
// Shared types, constants and mixing functions for the ISAAC random word generator.
// Used by every module of the block; depends on nothing.
package irw_pkg;

   // Default pool depth in words
   localparam int POOL_WORDS_DEF = 256;

   // Request command codes
   localparam logic CMD_RESEED = 1'b0;
   localparam logic CMD_NEXT   = 1'b1;

   // Eight mixing words
   typedef logic [7:0][31:0] w8_type;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_SEED_LOAD,
      OP_MIX,
      OP_LOAD_RD,
      OP_LOAD_ADD,
      OP_STORE,
      OP_NEXT_BLK,
      OP_RND_START,
      OP_RD_X,
      OP_RD_MID,
      OP_ACC,
      OP_RD_MOD,
      OP_WR_Y,
      OP_WR_R,
      OP_OUT_RD,
      OP_OUT_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_last;       // word index at last pool entry
      logic mix_last;       // last line of one mix
      logic init_mix_last;  // last line of the four initial mixes
      logic k_last;         // last word within a block
      logic blk_last;       // last block of a seeding pass
      logic mod_busy;       // index reduction still running
      logic rd_empty;       // result table used up
   } dp_status_type;

   // Shift of one mix line
   function automatic logic [31:0] mix_shift(input logic [31:0] v, input logic [2:0] j);
      logic [31:0] r;
      case (j)
         3'd0:    r = v << 11;
         3'd1:    r = v >> 2;
         3'd2:    r = v << 8;
         3'd3:    r = v >> 16;
         3'd4:    r = v << 10;
         3'd5:    r = v >> 4;
         3'd6:    r = v << 8;
         default: r = v >> 9;
      endcase
      return r;
   endfunction

   // One line of the eight-word mix
   function automatic w8_type mix_step(input w8_type w, input logic [2:0] j);
      logic [2:0]  b;
      logic [2:0]  c;
      logic [2:0]  d;
      logic [31:0] t;
      w8_type      r;
      b    = j + 3'd1;
      c    = j + 3'd2;
      d    = j + 3'd3;
      t    = w[j] ^ mix_shift(w[b], j);
      r    = w;
      r[j] = t;
      r[d] = w[d] + t;
      r[b] = w[b] + w[c];
      return r;
   endfunction

   // Accumulator scramble chosen by word index modulo four
   function automatic logic [31:0] accum_mix(input logic [31:0] a, input logic [1:0] sel);
      logic [31:0] r;
      case (sel)
         2'd0:    r = a ^ (a << 13);
         2'd1:    r = a ^ (a >> 6);
         2'd2:    r = a ^ (a << 2);
         default: r = a ^ (a >> 16);
      endcase
      return r;
   endfunction

endpackage

### rtl/isaac_random_word_generator.sv
// ISAAC-32 random word generator, top level: controller plus datapath.
// Depends on irw_pkg, irw_ctrl, irw_datapath.
//
// Usage: a request with req_cmd = reseed loads req_seed_value, runs the seeding
// passes and one generation round, and returns nothing. A request with req_cmd =
// next returns one 32-bit word on rsp_random_word, words taken in table order.
// After reset the block stalls requests while it zeroes the pool and the result
// table. A next request reads the table word and then loads it into the result
// register; when the table is used up it first runs a round. A round steps
// through the pool words in turn, with four reads and one write per word on the
// single pool memory port; when POOL_WORDS is not a power of two, each word also
// waits on the two index reductions. A reseed runs four initial mixes and two
// passes over B = ceil(POOL_WORDS / 8) blocks of mixing, then a round.
// The result register holds its word while rsp_stall is high; a new request is
// accepted meanwhile, and its delivery waits until the register is free.
module isaac_random_word_generator #(
   parameter int POOL_WORDS = irw_pkg::POOL_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_random_word
);

   irw_pkg::dp_cmd_type    dp_cmd;
   irw_pkg::dp_status_type dp_status;

   irw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   irw_datapath #(.POOL_WORDS(POOL_WORDS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .seed_value  (req_seed_value),
      .status      (dp_status),
      .random_word (rsp_random_word)
   );

endmodule

### rtl/irw_mod_unit.sv
// Reduces a 32-bit value modulo the pool depth to form a pool index.
// Eight bits per cycle when the depth is not a power of two; depends on irw_pkg.
module irw_mod_unit #(
   parameter int POOL_WORDS = irw_pkg::POOL_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   value,
   output logic                          busy,
   output logic [$clog2(POOL_WORDS)-1:0] result
);

   localparam int IDX_W = $clog2(POOL_WORDS);
   localparam int RW    = IDX_W + 1;
   localparam bit POW2  = (POOL_WORDS & (POOL_WORDS - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic [IDX_W-1:0] result_ff;

         // Keep the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               result_ff <= '0;
            end else if (start) begin
               result_ff <= value[IDX_W-1:0];
            end
         end

         assign busy   = 1'b0;
         assign result = result_ff;
      end else begin : g_iter
         logic [RW-1:0] rem_ff, rem_in;
         logic [31:0]   shift_ff;
         logic [1:0]    cnt_ff;
         logic          busy_ff;

         // Consume eight bits, restoring after each
         always_comb begin
            rem_in = rem_ff;
            for (int b = 0; b < 8; b++) begin
               rem_in = {rem_in[RW-2:0], shift_ff[31-b]};
               if (rem_in >= RW'(POOL_WORDS)) begin
                  rem_in = rem_in - RW'(POOL_WORDS);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               cnt_ff  <= '0;
            end else if (start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
            end else if (busy_ff) begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  busy_ff <= 1'b0;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               shift_ff <= value;
               rem_ff   <= '0;
            end else if (busy_ff) begin
               shift_ff <= shift_ff << 8;
               rem_ff   <= rem_in;
            end
         end

         assign busy   = busy_ff;
         assign result = rem_ff[IDX_W-1:0];
      end
   endgenerate

endmodule

### rtl/irw_datapath.sv
// Datapath: pool and result memories, mixing words, accumulators and index counters.
// Executes one controller operation per cycle; depends on irw_pkg and irw_mod_unit.
module irw_datapath #(
   parameter int POOL_WORDS = irw_pkg::POOL_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  irw_pkg::dp_cmd_type   cmd,
   input  logic [31:0]           seed_value,
   output irw_pkg::dp_status_type status,
   output logic [31:0]           random_word
);

   localparam int IDX_W = $clog2(POOL_WORDS);
   localparam int CNT_W = $clog2(POOL_WORDS + 1);
   localparam int POS_W = CNT_W + 1;

   logic [31:0] pool_mem [POOL_WORDS];
   logic [31:0] res_mem  [POOL_WORDS];

   logic [31:0]     pool_rd_ff, res_rd_ff;
   irw_pkg::w8_type w_ff, w_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [2:0]      k_ff, k_in;
   logic [4:0]      mc_ff, mc_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [31:0]     acc_ff, acc_in;
   logic [31:0]     last_ff, last_in;
   logic [31:0]     rc_ff, rc_in;
   logic [31:0]     x_ff, x_in;
   logic [31:0]     word_ff, word_in;

   logic [POS_W-1:0] pos, mid_sum, mid;
   logic             pos_ok;
   logic [31:0]      y_calc, r_calc;
   logic [IDX_W-1:0] pool_addr, res_addr, mod_result;
   logic             pool_we, res_we;
   logic [31:0]      pool_wd, res_wd;
   logic             mod_start, mod_busy;
   logic [31:0]      mod_value;
   irw_pkg::op_type  op;

   assign op = cmd.op;

   // Address helpers
   assign pos     = POS_W'(i_ff) + POS_W'(k_ff);
   assign pos_ok  = pos < POS_W'(POOL_WORDS);
   assign mid_sum = POS_W'(i_ff) + POS_W'(POOL_WORDS / 2);
   assign mid     = (mid_sum >= POS_W'(POOL_WORDS)) ? mid_sum - POS_W'(POOL_WORDS) : mid_sum;
   assign y_calc  = pool_rd_ff + acc_ff + last_ff;
   assign r_calc  = pool_rd_ff + x_ff;

   // Index reduction for the indirect pool reads
   assign mod_start = (op == irw_pkg::OP_ACC) || (op == irw_pkg::OP_WR_Y);
   assign mod_value = (op == irw_pkg::OP_ACC) ? {2'b0, x_ff[31:2]} : {10'b0, y_calc[31:10]};

   irw_mod_unit #(.POOL_WORDS(POOL_WORDS)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .busy   (mod_busy),
      .result (mod_result)
   );

   // Pool port select
   always_comb begin
      pool_addr = i_ff[IDX_W-1:0];
      pool_we   = 1'b0;
      pool_wd   = '0;
      case (op)
         irw_pkg::OP_CLEAR: begin
            pool_we = 1'b1;
         end
         irw_pkg::OP_LOAD_RD: begin
            pool_addr = pos[IDX_W-1:0];
         end
         irw_pkg::OP_STORE: begin
            pool_addr = pos[IDX_W-1:0];
            pool_we   = pos_ok;
            pool_wd   = w_ff[k_ff];
         end
         irw_pkg::OP_RD_MID: begin
            pool_addr = mid[IDX_W-1:0];
         end
         irw_pkg::OP_RD_MOD: begin
            pool_addr = mod_result;
         end
         irw_pkg::OP_WR_Y: begin
            pool_we = 1'b1;
            pool_wd = y_calc;
         end
         default: begin
         end
      endcase
   end

   // Result table port select
   always_comb begin
      res_addr = i_ff[IDX_W-1:0];
      res_we   = 1'b0;
      res_wd   = '0;
      case (op)
         irw_pkg::OP_CLEAR: begin
            res_we = 1'b1;
         end
         irw_pkg::OP_WR_R: begin
            res_we = 1'b1;
            res_wd = r_calc;
         end
         irw_pkg::OP_OUT_RD: begin
            res_addr = rd_idx_ff[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // Memories with registered reads
   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_addr] <= pool_wd;
      end
      pool_rd_ff <= pool_mem[pool_addr];
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_addr] <= res_wd;
      end
      res_rd_ff <= res_mem[res_addr];
   end

   // Next values of the working registers
   always_comb begin
      w_in      = w_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      mc_in     = mc_ff;
      rd_idx_in = rd_idx_ff;
      acc_in    = acc_ff;
      last_in   = last_ff;
      rc_in     = rc_ff;
      x_in      = x_ff;
      word_in   = word_ff;
      case (op)
         irw_pkg::OP_CLEAR: begin
            i_in = i_ff + CNT_W'(1);
         end
         irw_pkg::OP_SEED_LOAD: begin
            w_in    = {8{seed_value}};
            i_in    = '0;
            k_in    = '0;
            mc_in   = '0;
            acc_in  = '0;
            last_in = '0;
            rc_in   = '0;
         end
         irw_pkg::OP_MIX: begin
            w_in  = irw_pkg::mix_step(w_ff, mc_ff[2:0]);
            mc_in = mc_ff + 5'd1;
         end
         irw_pkg::OP_LOAD_ADD: begin
            if (pos_ok) begin
               w_in[k_ff] = w_ff[k_ff] + pool_rd_ff;
            end
            k_in = k_ff + 3'd1;
         end
         irw_pkg::OP_STORE: begin
            k_in = k_ff + 3'd1;
         end
         irw_pkg::OP_NEXT_BLK: begin
            i_in = status.blk_last ? '0 : i_ff + CNT_W'(8);
         end
         irw_pkg::OP_RND_START: begin
            rc_in     = rc_ff + 32'd1;
            last_in   = last_ff + rc_ff + 32'd1;
            i_in      = '0;
            rd_idx_in = '0;
         end
         irw_pkg::OP_RD_MID: begin
            x_in   = pool_rd_ff;
            acc_in = irw_pkg::accum_mix(acc_ff, i_ff[1:0]);
         end
         irw_pkg::OP_ACC: begin
            acc_in = pool_rd_ff + acc_ff;
         end
         irw_pkg::OP_WR_R: begin
            last_in = r_calc;
            i_in    = i_ff + CNT_W'(1);
         end
         irw_pkg::OP_OUT_LOAD: begin
            word_in   = res_rd_ff;
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Counters and round state
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff      <= '0;
         k_ff      <= '0;
         mc_ff     <= '0;
         rd_idx_ff <= '0;
         acc_ff    <= '0;
         last_ff   <= '0;
         rc_ff     <= '0;
      end else begin
         i_ff      <= i_in;
         k_ff      <= k_in;
         mc_ff     <= mc_in;
         rd_idx_ff <= rd_idx_in;
         acc_ff    <= acc_in;
         last_ff   <= last_in;
         rc_ff     <= rc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      x_ff    <= x_in;
      word_ff <= word_in;
   end

   // Status back to the controller
   always_comb begin
      status.idx_last      = i_ff == CNT_W'(POOL_WORDS - 1);
      status.mix_last      = mc_ff[2:0] == 3'd7;
      status.init_mix_last = mc_ff == 5'd31;
      status.k_last        = k_ff == 3'd7;
      status.blk_last      = (POS_W'(i_ff) + POS_W'(8)) >= POS_W'(POOL_WORDS);
      status.mod_busy      = mod_busy;
      status.rd_empty      = rd_idx_ff == CNT_W'(POOL_WORDS);
   end

   assign random_word = word_ff;

endmodule

### rtl/irw_ctrl.sv
// Controller: sequences the clearing pass, reseeding, generation rounds and delivery.
// Drives datapath operations from status; depends on irw_pkg.
module irw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output irw_pkg::dp_cmd_type   cmd,
   input  irw_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_INIT_MIX,
      S_LOAD_RD,
      S_LOAD_ADD,
      S_BLK_MIX,
      S_STORE,
      S_NEXT_BLK,
      S_RND_START,
      S_RD_X,
      S_RD_MID,
      S_ACC,
      S_WAIT_X,
      S_WR_Y,
      S_WAIT_Y,
      S_WR_R,
      S_OUT_RD,
      S_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      from_next_ff, from_next_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Operation for the current state
   always_comb begin
      cmd.op = irw_pkg::OP_NONE;
      case (state_ff)
         S_CLEAR:     cmd.op = irw_pkg::OP_CLEAR;
         S_IDLE: begin
            if (accept && req_cmd == irw_pkg::CMD_RESEED) begin
               cmd.op = irw_pkg::OP_SEED_LOAD;
            end
         end
         S_INIT_MIX:  cmd.op = irw_pkg::OP_MIX;
         S_BLK_MIX:   cmd.op = irw_pkg::OP_MIX;
         S_LOAD_RD:   cmd.op = irw_pkg::OP_LOAD_RD;
         S_LOAD_ADD:  cmd.op = irw_pkg::OP_LOAD_ADD;
         S_STORE:     cmd.op = irw_pkg::OP_STORE;
         S_NEXT_BLK:  cmd.op = irw_pkg::OP_NEXT_BLK;
         S_RND_START: cmd.op = irw_pkg::OP_RND_START;
         S_RD_X:      cmd.op = irw_pkg::OP_RD_X;
         S_RD_MID:    cmd.op = irw_pkg::OP_RD_MID;
         S_ACC:       cmd.op = irw_pkg::OP_ACC;
         S_WAIT_X, S_WAIT_Y: begin
            if (!status.mod_busy) begin
               cmd.op = irw_pkg::OP_RD_MOD;
            end
         end
         S_WR_Y:      cmd.op = irw_pkg::OP_WR_Y;
         S_WR_R:      cmd.op = irw_pkg::OP_WR_R;
         S_OUT_RD:    cmd.op = irw_pkg::OP_OUT_RD;
         // Keep the table word read until the result register frees up
         S_OUT_WAIT: begin
            if (out_free) begin
               cmd.op = irw_pkg::OP_OUT_LOAD;
            end else begin
               cmd.op = irw_pkg::OP_OUT_RD;
            end
         end
         default: cmd.op = irw_pkg::OP_NONE;
      endcase
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      from_next_in = from_next_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == irw_pkg::CMD_RESEED) begin
                  state_in     = S_INIT_MIX;
                  pass_in      = 1'b0;
                  from_next_in = 1'b0;
               end else if (status.rd_empty) begin
                  state_in     = S_RND_START;
                  from_next_in = 1'b1;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         S_INIT_MIX: begin
            if (status.init_mix_last) state_in = S_BLK_MIX;
         end
         S_LOAD_RD:  state_in = S_LOAD_ADD;
         S_LOAD_ADD: state_in = status.k_last ? S_BLK_MIX : S_LOAD_RD;
         S_BLK_MIX: begin
            if (status.mix_last) state_in = S_STORE;
         end
         S_STORE: begin
            if (status.k_last) state_in = S_NEXT_BLK;
         end
         S_NEXT_BLK: begin
            if (status.blk_last) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_LOAD_RD;
               end else begin
                  state_in = S_RND_START;
               end
            end else begin
               state_in = pass_ff ? S_LOAD_RD : S_BLK_MIX;
            end
         end
         S_RND_START: state_in = S_RD_X;
         S_RD_X:      state_in = S_RD_MID;
         S_RD_MID:    state_in = S_ACC;
         S_ACC:       state_in = S_WAIT_X;
         S_WAIT_X: begin
            if (!status.mod_busy) state_in = S_WR_Y;
         end
         S_WR_Y:      state_in = S_WAIT_Y;
         S_WAIT_Y: begin
            if (!status.mod_busy) state_in = S_WR_R;
         end
         S_WR_R: begin
            if (status.idx_last) begin
               state_in = from_next_ff ? S_OUT_RD : S_IDLE;
            end else begin
               state_in = S_RD_X;
            end
         end
         S_OUT_RD:    state_in = S_OUT_WAIT;
         S_OUT_WAIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == irw_pkg::OP_OUT_LOAD) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pass_ff      <= 1'b0;
         from_next_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         from_next_ff <= from_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/irw_checker.sv
// Port-level checks for the ISAAC random word generator, bound to the top level.
// Depends on isaac_random_word_generator and irw_pkg.
module irw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_cmd,
   input logic [31:0] req_seed_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_random_word
);

   // A waiting result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A waiting result keeps its word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_random_word))
      else $error("result word changed while stalled");

   // Clearing pass follows reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // A reseed request makes the block busy and yields no result
   a_reseed_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == irw_pkg::CMD_RESEED && !rsp_valid
      |=> req_stall && !rsp_valid)
      else $error("reseed request produced a result or was not processed");

endmodule

bind isaac_random_word_generator irw_checker u_irw_checker (.*);
